@@ design/rct_pkg.sv @@
// Package with the constants and types of the random curve thinning core.
`timescale 1ns / 1ps
`default_nettype none

package rct_pkg;

	// Lag word of the subtract-with-borrow generator.
	typedef logic [23:0] word_t;

	// Index into the ring of lag words.
	typedef logic [4:0] ring_t;

	// Seeding congruential generator: x = 40014 * x mod 2147483563.
	localparam logic [30:0] LCG_MOD      = 31'd2147483563;
	localparam logic [15:0] LCG_MUL      = 16'd40014;
	// 2^31 mod LCG_MOD, used to fold the high part of a product.
	localparam logic [6:0]  FOLD_K       = 7'd85;
	localparam logic [30:0] DEFAULT_SEED = 31'd19780503;

	// Generator geometry.
	localparam int          LAG_LONG     = 24;
	localparam int          LAG_SHORT    = 10;
	localparam logic [4:0]  BLOCK_USED   = 5'd23;
	localparam logic [7:0]  DISCARD_RUN  = 8'd201;
	localparam logic [4:0]  LAST_WORD    = 5'd23;
	localparam logic [4:0]  SHORT_OFFS   = 5'd14;

	// A threshold at or above this value keeps every curve.
	localparam logic [24:0] THR_FULL     = 25'h0FFFFFF;
	localparam logic [24:0] THR_RESET    = 25'h1000000;

	// Register indexes on the configuration port.
	localparam logic        REG_THRESHOLD = 1'b0;
	localparam logic        REG_SEED      = 1'b1;

	// Kind codes of an input transfer.
	localparam logic        KIND_START   = 1'b0;
	localparam logic        KIND_CURVE   = 1'b1;

endpackage

`default_nettype wire

@@ design/random_curve_thinning_core.sv @@
// Top level of the random curve thinning core: seeding, generator and result logic.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Signals                      Content
// s_*       in         s_tvalid/s_tready            start or curve item
// m_*       out        m_tvalid/m_tready            one result per curve item
// APB       in/out     psel/penable/pwrite/...      keep_threshold, seed_value
//
// A curve item runs one generator step through the two-port read of the lag-word
// memory, then the execute step and the result state. Every 24th curve also runs
// 200 discarded steps at one step a cycle.
// A start item runs two folds of the seed and one pass through the shared
// compare-subtract unit, then a multiply, fold and compare-subtract per lag word.
// After reset the lag words are seeded from the default seed with s_tready
// low. A result waiting on m_tready stalls only the next curve.

module random_curve_thinning_core #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Input stream.
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// tdata fields from bit 0: vertex_count.
	input  wire logic [((COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	// tuser fields from bit 0: kind.
	input  wire logic                                 s_tuser,
	// Output stream.
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// tdata fields from bit 0: curve_dropped, first_point, point_count,
	// dropped_total, index_overflow.
	output logic [((COUNT_BITS + 72) / 8) * 8 - 1:0]  m_tdata,
	// Configuration port.
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [3:0]                           paddr,
	input  wire logic [63:0]                          pwdata,
	output logic [63:0]                               prdata,
	output logic                                      pready
);
	import rct_pkg::*;

	localparam int OUT_W = ((COUNT_BITS + 72) / 8) * 8;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RED  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_FOLD = 3'd3;
	localparam logic [2:0] S_SUB  = 3'd4;
	localparam logic [2:0] S_RUN  = 3'd5;
	localparam logic [2:0] S_PUSH = 3'd6;

	logic [2:0]            state_q;
	logic [24:0]           thr_q;
	logic [63:0]           seed_q;

	logic [1:0]            fold_cnt_q;
	logic [30:0]           x_q;
	logic [63:0]           prod_q;
	logic [31:0]           sum_q;
	logic [4:0]            word_idx_q;

	word_t                 mem_q [LAG_LONG];
	word_t                 a_q;
	word_t                 b_q;
	logic                  borrow_q;
	ring_t                 rd_pos_q;
	ring_t                 ex_pos_q;
	logic                  ex_vld_q;
	logic [4:0]            draws_q;
	logic [7:0]            issue_left_q;
	logic [7:0]            exec_left_q;
	word_t                 draw_q;

	logic [30:0]           idx_q;
	logic [31:0]           drops_q;
	logic                  ovf_q;
	logic [COUNT_BITS-1:0] cnt_q;

	logic                  m_tvalid_q;
	logic                  o_dropped_q;
	logic [30:0]           o_first_q;
	logic [COUNT_BITS-1:0] o_count_q;
	logic [31:0]           o_total_q;
	logic                  o_ovf_q;

	logic                  in_xfer;
	logic                  cfg_wr;
	logic [63:0]           fold;
	logic [31:0]           sub_in;
	logic [30:0]           sub_out;
	logic                  rd_en;
	ring_t                 rd_short;
	ring_t                 rd_next;
	logic [24:0]           diff;
	word_t                 nv;
	logic                  wr_en;
	ring_t                 wr_addr;
	word_t                 wr_data;
	logic                  push;
	logic                  dropped;
	logic [31:0]           next_idx;

	assign s_tready = (state_q == S_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign m_tvalid = m_tvalid_q;

	// Register reads; the low address bits are ignored.
	always_comb begin
		prdata = 64'(thr_q);
		if (paddr[3] == REG_SEED) begin
			prdata = seed_q;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= THR_RESET;
			seed_q <= 64'(DEFAULT_SEED);
		end else if (cfg_wr) begin
			if (paddr[3] == REG_THRESHOLD) begin
				thr_q <= pwdata[24:0];
			end else begin
				seed_q <= pwdata;
			end
		end
	end

	// Fold unit: the part above bit 30 comes back in times 2^31 mod the modulus.
	assign fold = 64'(prod_q[30:0]) + 64'(40'(prod_q[63:31]) * 40'(FOLD_K));

	// Shared compare-subtract unit: reduces a value below twice the modulus.
	always_comb begin
		sub_in = sum_q;
		if (state_q == S_RED) begin
			sub_in = prod_q[31:0];
		end
		if (sub_in >= 32'(LCG_MOD)) begin
			sub_out = 31'(sub_in - 32'(LCG_MOD));
		end else begin
			sub_out = sub_in[30:0];
		end
	end

	// Generator step: read addresses, subtraction with borrow.
	assign rd_en    = (state_q == S_RUN) && (issue_left_q != 8'd0);
	assign rd_short = (rd_pos_q >= 5'(LAG_SHORT)) ? rd_pos_q - 5'(LAG_SHORT)
	                                              : rd_pos_q + SHORT_OFFS;
	assign rd_next  = (rd_pos_q == LAST_WORD) ? 5'd0 : rd_pos_q + 5'd1;
	assign diff     = {1'b0, a_q} - {1'b0, b_q} - 25'(borrow_q);
	assign nv       = diff[23:0];

	// One write port shared by seeding and generator steps.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ex_pos_q;
		wr_data = nv;
		if (state_q == S_SUB) begin
			wr_en   = 1'b1;
			wr_addr = word_idx_q;
			wr_data = sub_out[23:0];
		end else if (ex_vld_q) begin
			wr_en = 1'b1;
		end
	end

	// Lag-word memory with registered reads.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			a_q <= mem_q[rd_short];
			b_q <= mem_q[rd_pos_q];
		end
	end

	// Result of a curve: drop decision and point index update.
	assign push     = (state_q == S_PUSH) && (!m_tvalid_q || m_tready);
	assign dropped  = (thr_q < THR_FULL) && (25'(draw_q) >= thr_q);
	assign next_idx = {1'b0, idx_q} + 32'(cnt_q);

	// Sequencer for seeding, generator steps and results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_MUL;
			x_q          <= DEFAULT_SEED;
			word_idx_q   <= 5'd0;
			borrow_q     <= 1'b0;
			rd_pos_q     <= 5'd0;
			ex_pos_q     <= 5'd0;
			ex_vld_q     <= 1'b0;
			draws_q      <= 5'd0;
			issue_left_q <= 8'd0;
			exec_left_q  <= 8'd0;
			fold_cnt_q   <= 2'd0;
			idx_q        <= 31'd0;
			drops_q      <= 32'd0;
			ovf_q        <= 1'b0;
			m_tvalid_q   <= 1'b0;
		end else begin
			ex_vld_q <= rd_en;
			ex_pos_q <= rd_pos_q;
			if (rd_en) begin
				rd_pos_q     <= rd_next;
				issue_left_q <= issue_left_q - 8'd1;
			end
			if (ex_vld_q) begin
				borrow_q    <= diff[24];
				exec_left_q <= exec_left_q - 8'd1;
			end
			if (push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (in_xfer && s_tuser == KIND_START) begin
						prod_q     <= (seed_q == 64'd0) ? 64'(DEFAULT_SEED) : seed_q;
						fold_cnt_q <= 2'd2;
						idx_q      <= 31'd0;
						drops_q    <= 32'd0;
						ovf_q      <= 1'b0;
						state_q    <= S_RED;
					end else if (in_xfer) begin
						cnt_q <= s_tdata[COUNT_BITS-1:0];
						if (draws_q >= BLOCK_USED) begin
							issue_left_q <= DISCARD_RUN;
							exec_left_q  <= DISCARD_RUN;
							draws_q      <= 5'd1;
						end else begin
							issue_left_q <= 8'd1;
							exec_left_q  <= 8'd1;
							draws_q      <= draws_q + 5'd1;
						end
						state_q <= S_RUN;
					end
				end
				S_RED: begin
					// Two folds bring the seed below 2^32, then one compare-subtract.
					if (fold_cnt_q != 2'd0) begin
						prod_q     <= fold;
						fold_cnt_q <= fold_cnt_q - 2'd1;
					end else begin
						x_q        <= (sub_out == 31'd0) ? 31'd1 : sub_out;
						word_idx_q <= 5'd0;
						state_q    <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= 64'(47'(x_q) * 47'(LCG_MUL));
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					sum_q   <= fold[31:0];
					state_q <= S_SUB;
				end
				S_SUB: begin
					x_q <= sub_out;
					if (word_idx_q == LAST_WORD) begin
						borrow_q <= (sub_out[23:0] == 24'd0);
						rd_pos_q <= 5'd0;
						draws_q  <= 5'd0;
						state_q  <= S_IDLE;
					end else begin
						word_idx_q <= word_idx_q + 5'd1;
						state_q    <= S_MUL;
					end
				end
				S_RUN: begin
					// The last executed step gives the draw.
					if (ex_vld_q && exec_left_q == 8'd1) begin
						draw_q  <= nv;
						state_q <= S_PUSH;
					end
				end
				S_PUSH: begin
					if (push) begin
						o_dropped_q <= dropped;
						o_first_q   <= idx_q;
						o_count_q   <= cnt_q;
						o_ovf_q     <= ovf_q || next_idx[31];
						if (dropped && drops_q != 32'hFFFFFFFF) begin
							o_total_q <= drops_q + 32'd1;
							drops_q   <= drops_q + 32'd1;
						end else begin
							o_total_q <= drops_q;
						end
						if (next_idx[31]) begin
							ovf_q <= 1'b1;
						end
						idx_q   <= next_idx[30:0];
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output packing.
	always_comb begin
		m_tdata                               = '0;
		m_tdata[0]                            = o_dropped_q;
		m_tdata[31:1]                         = o_first_q;
		m_tdata[32 +: COUNT_BITS]             = o_count_q;
		m_tdata[32 + COUNT_BITS +: 32]        = o_total_q;
		m_tdata[64 + COUNT_BITS]              = o_ovf_q;
	end

	// An execute cycle always follows a read issued in the run state.
	assert property (@(posedge clk) disable iff (!arst_n)
		ex_vld_q |-> $past(state_q) == S_RUN)
		else $error("generator step executed without a read");

	// A step never executes once all steps of the item are done.
	assert property (@(posedge clk) disable iff (!arst_n)
		ex_vld_q |-> exec_left_q != 8'd0)
		else $error("generator step count underflow");

	// An accepted curve starts generator steps in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && s_tuser == KIND_CURVE) |=> (state_q == S_RUN && rd_en))
		else $error("curve transfer did not start a draw");

	// Seeding ends after the last lag word with the ring rewound.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUB && word_idx_q == LAST_WORD) |=>
		(state_q == S_IDLE && rd_pos_q == 5'd0 && draws_q == 5'd0))
		else $error("seeding did not finish cleanly");

	// The draw counter never passes the used part of a block.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (draws_q <= BLOCK_USED && draws_q != 5'd0))
		else $error("draw counter out of range");

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Testbench of the random curve thinning core: directed, random and stress tests with a predictor.
`timescale 1ns / 1ps

module tb;
	import rct_pkg::*;

	localparam int          CNT_W         = 16;
	localparam int unsigned CYCLE_LIMIT   = 3000000;
	localparam int          SETTLE_CYCLES = 300;
	localparam int          PRINT_CAP     = 20;
	localparam int          HOLD_CYCLES   = 400;

	// Constants of the seeding generator and of the lagged generator.
	localparam logic [63:0] SEED_MODULUS  = 64'd2147483563;
	localparam logic [63:0] SEED_MULT     = 64'd40014;
	localparam logic [63:0] SEED_FALLBACK = 64'd19780503;
	localparam int          RING_LEN      = 24;
	localparam int          TAP_OFFSET    = 14;
	localparam int          DRAWS_KEPT    = 23;
	localparam int          DRAWS_SKIPPED = 200;
	localparam logic [24:0] KEEP_ALL      = 25'h0FFFFFF;
	localparam logic [24:0] KEEP_RESET    = 25'h1000000;
	localparam logic [30:0] INDEX_MAX     = 31'h7FFFFFFF;

	// One expected result transfer.
	typedef struct packed {
		logic        dropped;
		logic [30:0] first;
		logic [15:0] count;
		logic [31:0] total;
		logic        wrapped;
	} curve_verdict_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	// Fields from bit 0: vertex_count.
	logic [15:0] s_tdata;
	// Fields from bit 0: kind.
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	// Fields from bit 0: curve_dropped, first_point, point_count, dropped_total,
	// index_overflow.
	logic [87:0] m_tdata;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	// Predictor state and its copy of the registers.
	logic [23:0]    lag_ring [RING_LEN];
	logic           swb_borrow;
	int             ring_pos;
	int             kept_draws;
	logic [30:0]    next_point;
	logic [31:0]    drop_tally;
	logic           wrap_seen;
	logic [24:0]    threshold_reg;
	logic [63:0]    seed_reg;
	curve_verdict_t curve_verdicts_q [$];

	int unsigned    mismatch_count = 0;
	int unsigned    cycle_count = 0;
	int             burst_left = 0;
	bit             pace_on = 1'b0;
	int             sink_hold = 0;
	bit             sink_steady = 1'b0;

	random_curve_thinning_core #(
		.COUNT_BITS(CNT_W)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Refill the lag words from the congruential seeding generator.
	function automatic void reseed_generator();
		logic [63:0] lcg;
		int          i;
		lcg = (seed_reg == 64'd0) ? SEED_FALLBACK : seed_reg;
		lcg = lcg % SEED_MODULUS;
		if (lcg == 64'd0)
			lcg = 64'd1;
		for (i = 0; i < RING_LEN; i++) begin
			lcg = (lcg * SEED_MULT) % SEED_MODULUS;
			lag_ring[i] = lcg[23:0];
		end
		swb_borrow = (lag_ring[RING_LEN - 1] == 24'd0);
		ring_pos = 0;
		kept_draws = 0;
	endfunction

	// A start reseeds and clears the per-geometry counters.
	function automatic void start_geometry();
		reseed_generator();
		next_point = 31'd0;
		drop_tally = 32'd0;
		wrap_seen = 1'b0;
	endfunction

	// One subtract-with-borrow step; the new word replaces the long-lag word.
	function automatic logic [23:0] swb_next();
		logic [23:0] a;
		logic [23:0] b;
		logic [23:0] w;
		a = lag_ring[(ring_pos + TAP_OFFSET) % RING_LEN];
		b = lag_ring[ring_pos];
		w = a - b - {23'd0, swb_borrow};
		swb_borrow = ({1'b0, a} < ({1'b0, b} + {24'd0, swb_borrow}));
		lag_ring[ring_pos] = w;
		ring_pos = (ring_pos + 1) % RING_LEN;
		return w;
	endfunction

	// Predict the effect of one accepted input transfer.
	function automatic void thin_curve_item(input logic kind, input logic [15:0] count);
		logic [23:0]    x;
		logic [31:0]    sum;
		curve_verdict_t v;
		if (kind == KIND_START) begin
			start_geometry();
		end else begin
			// After every 23 kept draws the generator throws away 200 steps.
			if (kept_draws >= DRAWS_KEPT) begin
				repeat (DRAWS_SKIPPED) void'(swb_next());
				kept_draws = 0;
			end
			kept_draws++;
			x = swb_next();
			v.dropped = (threshold_reg < KEEP_ALL) && ({1'b0, x} >= threshold_reg);
			if (v.dropped && drop_tally != 32'hFFFFFFFF)
				drop_tally++;
			v.first = next_point;
			v.count = count;
			sum = {1'b0, next_point} + {16'd0, count};
			if (sum > {1'b0, INDEX_MAX})
				wrap_seen = 1'b1;
			next_point = sum[30:0];
			v.total = drop_tally;
			v.wrapped = wrap_seen;
			curve_verdicts_q.push_back(v);
		end
	endfunction

	function automatic void check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			mismatch_count++;
			if (mismatch_count <= PRINT_CAP)
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
					$time, what, want, got);
		end
	endfunction

	function automatic logic [15:0] random_count();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 15));
			1: return 16'($urandom_range(0, 1000));
			2: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Offer one item until it is transferred, then maybe leave a gap.
	task automatic send_item(input logic kind, input logic [15:0] count);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= count;
		do @(posedge clk); while (!s_tready);
		thin_curve_item(kind, count);
		if (pace_on) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(0, 12);
				gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Stop offering, wait for every pending result, then let the block go quiet.
	task automatic wait_idle(input int quiet_cycles);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (curve_verdicts_q.size() != 0)
			@(posedge clk);
		repeat (quiet_cycles) @(posedge clk);
	endtask

	// Write a register, then read it back.
	task automatic write_register(input logic idx, input logic [63:0] value);
		logic [63:0] stored;
		stored = (idx == REG_THRESHOLD) ? {39'd0, value[24:0]} : value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (idx == REG_THRESHOLD)
			threshold_reg = value[24:0];
		else
			seed_reg = value;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		check_field((idx == REG_THRESHOLD) ? "keep_threshold" : "seed_value", stored, prdata);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Curves that run on the generator state left by reset, at the field extremes.
	task automatic test_before_start();
		pace_on = 1'b0;
		send_item(KIND_CURVE, 16'h0000);
		send_item(KIND_CURVE, 16'hFFFF);
		send_item(KIND_CURVE, 16'h5555);
		send_item(KIND_CURVE, 16'hAAAA);
		send_item(KIND_CURVE, 16'h0001);
	endtask

	// Threshold extremes around full density and seeds that need replacing.
	task automatic test_register_extremes();
		logic [24:0] thr_set [5] = '{25'd0, 25'd1, 25'hFFFFFE, 25'hFFFFFF, 25'h1FFFFFF};
		logic [63:0] seed_set [5] = '{64'd0, 64'd2147483563, 64'hFFFFFFFFFFFFFFFF,
			64'd1, 64'd4294967126};
		int          i;
		pace_on = 1'b1;
		for (i = 0; i < 5; i++) begin
			wait_idle(SETTLE_CYCLES);
			write_register(REG_THRESHOLD, {39'd0, thr_set[i]});
			write_register(REG_SEED, seed_set[i]);
			send_item(KIND_START, random_count());
			send_item(KIND_CURVE, random_count());
			send_item(KIND_CURVE, random_count());
		end
	endtask

	// Random settings per phase; a phase may run on before its first start.
	task automatic test_random_phases();
		logic [24:0] thr;
		logic [63:0] seed;
		int          phase;
		int          n;
		pace_on = 1'b1;
		for (phase = 0; phase < 10; phase++) begin
			wait_idle(SETTLE_CYCLES);
			case ($urandom_range(0, 5))
				0: thr = 25'd0;
				1: thr = 25'($urandom_range(25'h1000000, 25'h1FFFFFF));
				2: thr = ($urandom_range(0, 1) != 0) ? 25'hFFFFFF : 25'hFFFFFE;
				default: thr = 25'($urandom_range(0, 25'h1000000));
			endcase
			case ($urandom_range(0, 4))
				0: seed = 64'd0;
				1: seed = 64'($urandom_range(1, 1000));
				2: seed = SEED_MODULUS * 64'($urandom_range(1, 5));
				default: seed = {$urandom, $urandom};
			endcase
			write_register(REG_THRESHOLD, {39'd0, thr});
			write_register(REG_SEED, seed);
			if ($urandom_range(0, 3) != 0)
				send_item(KIND_START, random_count());
			for (n = 0; n < 70; n++)
				send_item(($urandom_range(0, 24) == 0) ? KIND_START : KIND_CURVE, random_count());
		end
	endtask

	// The receiver holds off while curves keep coming, then the sender drains.
	task automatic test_backpressure();
		int n;
		wait_idle(SETTLE_CYCLES);
		write_register(REG_THRESHOLD, {39'd0, 25'h800000});
		pace_on = 1'b0;
		sink_hold = HOLD_CYCLES;
		send_item(KIND_START, random_count());
		for (n = 0; n < 30; n++)
			send_item(KIND_CURVE, random_count());
		wait_idle(0);
		pace_on = 1'b1;
		for (n = 0; n < 20; n++)
			send_item(KIND_CURVE, random_count());
	endtask

	// Full curves back to back with steady acceptance, then a start clears the counters.
	task automatic test_full_curves();
		int n;
		wait_idle(SETTLE_CYCLES);
		write_register(REG_THRESHOLD, {39'd0, 25'h800000});
		write_register(REG_SEED, {$urandom, $urandom});
		pace_on = 1'b0;
		sink_steady = 1'b1;
		send_item(KIND_START, 16'h0000);
		for (n = 0; n < 60; n++)
			send_item(KIND_CURVE, 16'hFFFF);
		sink_steady = 1'b0;
		pace_on = 1'b1;
		send_item(KIND_CURVE, random_count());
		send_item(KIND_CURVE, random_count());
		send_item(KIND_START, random_count());
		send_item(KIND_CURVE, random_count());
		send_item(KIND_CURVE, random_count());
	endtask

	// Result side: check each transfer and stall on a pattern of its own.
	initial begin : result_sink
		curve_verdict_t want;
		int             pattern_left;
		int             stall_pct;
		pattern_left = 0;
		stall_pct = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (curve_verdicts_q.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= PRINT_CAP)
						$display("%0t: result with none expected, expected none, actual 0x%0h",
							$time, m_tdata);
				end else begin
					want = curve_verdicts_q.pop_front();
					check_field("curve_dropped", 64'(want.dropped), 64'(m_tdata[0]));
					check_field("first_point", 64'(want.first), 64'(m_tdata[31:1]));
					check_field("point_count", 64'(want.count), 64'(m_tdata[47:32]));
					check_field("dropped_total", 64'(want.total), 64'(m_tdata[79:48]));
					check_field("index_overflow", 64'(want.wrapped), 64'(m_tdata[80]));
				end
			end
			// Long hold-off, steady acceptance, or stretches of random stalls.
			if (sink_hold > 0) begin
				sink_hold--;
				m_tready <= 1'b0;
			end else if (sink_steady) begin
				m_tready <= 1'b1;
			end else begin
				if (pattern_left == 0) begin
					pattern_left = $urandom_range(16, 96);
					case ($urandom_range(0, 2))
						0: stall_pct = 0;
						1: stall_pct = 25;
						default: stall_pct = 70;
					endcase
				end
				pattern_left--;
				m_tready <= ($urandom_range(0, 99) >= stall_pct);
			end
		end
	end

	// Run limit.
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	// Reset, the tests in turn, and the verdict.
	initial begin : stimulus
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = KIND_START;
		s_tdata = 16'd0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'd0;
		pwdata = 64'd0;
		threshold_reg = KEEP_RESET;
		seed_reg = SEED_FALLBACK;
		start_geometry();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		do @(posedge clk); while (!s_tready);
		test_before_start();
		test_register_extremes();
		test_random_phases();
		test_backpressure();
		test_full_curves();
		wait_idle(SETTLE_CYCLES);
		if (mismatch_count == 0 && curve_verdicts_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/rct_pkg.sv
design/random_curve_thinning_core.sv
test/tb.sv
